/* rtl/assert_macros.svh */
// Assertion macros used by the top level of the falling path sum unit.
// Needs signals clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while in reset.
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while in reset.
`define ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/mfps_pkg.sv */
// Shared constants and types of the falling path sum unit.
// No dependencies.
package mfps_pkg;

	localparam int CFG_W          = 7;
	localparam int MAX_COLS_DEF   = 64;
	localparam int VALUE_BITS_DEF = 16;
	localparam int SUM_BITS_DEF   = 32;
	localparam int OUT_W          = 32;
	localparam logic [CFG_W-1:0] NUM_COLS_RESET = 7'd64;

	// Flags of one cell in the compute stage.
	typedef struct packed {
		logic first;      // cell belongs to the first row of the grid
		logic has_left;   // column > 0
		logic has_right;  // column + 1 < row width
		logic last;       // final cell of the grid
		logic fwd_up;     // up score is being written back as the read happens
		logic fwd_right;  // same for the up-right score
	} s1_ctrl_t;

endpackage

/* rtl/max_falling_path_sum_unit.sv */
// Top level of the falling path sum unit.
// Uses mfps_pkg, mfps_front, mfps_score, mfps_ram and assert_macros.svh.
//
// Usage:
//  s_* stream carries grid cells in row-major order, one per request;
//  s_tlast marks the final cell of the grid. m_* stream returns one
//  best_sum request per grid. cfg_* writes num_cols (always ready); the
//  user must do so only while the unit is idle, not enforced by the block.
//  Throughput: one cell per cycle, except while a final cell is held back.
//  The row store is a single RAM with two read ports and one write port;
//  each cell reads its up and up-right scores at acceptance and writes
//  its own score in the cycle after, with the write forwarded to a read
//  of the same entry in that cycle. A final cell right behind another
//  waits while that one is in the compute stage. m_tvalid is registered.
//  Back-pressure: while a result waits on m_tready, cells keep flowing;
//  only the next final cell is held back until the result is taken.
//  Reset: num_cols returns to 64 and a new grid begins; the row store
//  is not cleared, since each grid writes its first row before reading.
module max_falling_path_sum_unit import mfps_pkg::*; #(
	parameter int MAX_COLS   = MAX_COLS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int SUM_BITS   = SUM_BITS_DEF,
	localparam int IN_TDATA_W = ((VALUE_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_W-1:0]      cfg_data,   // [6:0] num_cols
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,    // [VALUE_BITS-1:0] cell_value, rest zero
	input  logic                  s_tlast,    // last_cell
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_W-1:0]      m_tdata     // [31:0] best_sum
);

	`include "assert_macros.svh"

	localparam int ADDR_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int CNT_W  = $clog2(MAX_COLS + 1);

	logic                  ram_re;
	logic [ADDR_W-1:0]     ram_raddr0;
	logic [ADDR_W-1:0]     ram_raddr1;
	logic [SUM_BITS-1:0]   ram_rdata0;
	logic [SUM_BITS-1:0]   ram_rdata1;
	logic                  ram_we;
	logic [SUM_BITS-1:0]   ram_wdata;
	logic                  item_valid_s1;
	logic [VALUE_BITS-1:0] item_value_s1;
	logic [CNT_W-1:0]      item_col_s1;
	s1_ctrl_t              item_ctrl_s1;
	logic                  out_free;

	assign out_free = !m_tvalid || m_tready;

	mfps_front #(
		.MAX_COLS   (MAX_COLS),
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.cell_valid (s_tvalid),
		.cell_ready (s_tready),
		.cell_value (s_tdata[VALUE_BITS-1:0]),
		.last_cell  (s_tlast),
		.out_free   (out_free),
		.ram_re     (ram_re),
		.ram_raddr0 (ram_raddr0),
		.ram_raddr1 (ram_raddr1),
		.valid_s1   (item_valid_s1),
		.value_s1   (item_value_s1),
		.col_s1     (item_col_s1),
		.ctrl_s1    (item_ctrl_s1)
	);

	mfps_ram #(
		.WIDTH (SUM_BITS),
		.DEPTH (MAX_COLS)
	) u_row_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (item_col_s1[ADDR_W-1:0]),
		.wdata  (ram_wdata),
		.re     (ram_re),
		.raddr0 (ram_raddr0),
		.raddr1 (ram_raddr1),
		.rdata0 (ram_rdata0),
		.rdata1 (ram_rdata1)
	);

	mfps_score #(
		.VALUE_BITS (VALUE_BITS),
		.SUM_BITS   (SUM_BITS)
	) u_score (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (item_valid_s1),
		.value_s1  (item_value_s1),
		.ctrl_s1   (item_ctrl_s1),
		.rdata0    (ram_rdata0),
		.rdata1    (ram_rdata1),
		.ram_we    (ram_we),
		.ram_wdata (ram_wdata),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_data  (m_tdata)
	);

	`ASSERT_IMP(a_result_from_last, $rose(m_tvalid),
		$past(item_valid_s1 && item_ctrl_s1.last), "result without a final cell")
	`ASSERT_IMP(a_last_blocks_input, item_valid_s1 && item_ctrl_s1.last,
		!(s_tready && s_tlast), "final cell accepted behind a final cell")
	`ASSERT_IMP(a_col_in_range, item_valid_s1,
		item_col_s1 < CNT_W'(MAX_COLS), "row store write beyond depth")
	`ASSERT_IMP(a_fwd_needs_write, item_valid_s1 && (item_ctrl_s1.fwd_up || item_ctrl_s1.fwd_right),
		$past(item_valid_s1), "forward without a write in flight")

endmodule

/* rtl/mfps_ram.sv */
// Generic simple RAM: one write port, two registered read ports.
// No dependencies.
module mfps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr0,
	input  logic [ADDR_W-1:0] raddr1,
	output logic [WIDTH-1:0]  rdata0,
	output logic [WIDTH-1:0]  rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read returns the old contents on a same-address write
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

/* rtl/mfps_front.sv */
// Front end: config register, column tracking, row-store read addressing
// and write-back hazard detection. Uses mfps_pkg.
module mfps_front import mfps_pkg::*; #(
	parameter int MAX_COLS   = MAX_COLS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	localparam int ADDR_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
	localparam int CNT_W  = $clog2(MAX_COLS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  cell_valid,
	output logic                  cell_ready,
	input  logic [VALUE_BITS-1:0] cell_value,
	input  logic                  last_cell,
	input  logic                  out_free,
	output logic                  ram_re,
	output logic [ADDR_W-1:0]     ram_raddr0,
	output logic [ADDR_W-1:0]     ram_raddr1,
	output logic                  valid_s1,
	output logic [VALUE_BITS-1:0] value_s1,
	output logic [CNT_W-1:0]      col_s1,
	output s1_ctrl_t              ctrl_s1
);

	localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	logic [CFG_W-1:0] num_cols_q;
	logic [CNT_W-1:0] col_q;
	logic             first_q;

	logic [CMP_W-1:0] ncfg;
	logic [CNT_W-1:0] cols;
	logic             wrap;
	logic [CNT_W-1:0] col;
	logic [CNT_W-1:0] col_nxt;
	logic             first_eff;
	logic             accept;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cols_q <= NUM_COLS_RESET;
		end else if (cfg_valid) begin
			num_cols_q <= cfg_data;
		end
	end

	always_comb begin
		ncfg = CMP_W'(num_cols_q);
		if (ncfg == '0) begin
			cols = CNT_W'(1);
		end else if (ncfg > CMP_W'(MAX_COLS)) begin
			cols = CNT_W'(MAX_COLS);
		end else begin
			cols = ncfg[CNT_W-1:0];
		end
		// a shrunk row width restarts the row
		wrap      = (col_q >= cols);
		col       = wrap ? '0 : col_q;
		first_eff = wrap ? 1'b0 : first_q;
		col_nxt   = col + CNT_W'(1);
	end

	// a final cell may not enter while another result is still on its way
	assign cell_ready = !last_cell || (!(valid_s1 && ctrl_s1.last) && out_free);
	assign accept     = cell_valid && cell_ready;

	assign ram_re     = accept;
	assign ram_raddr0 = col[ADDR_W-1:0];
	assign ram_raddr1 = col_nxt[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			first_q  <= 1'b1;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (last_cell) begin
					col_q   <= '0;
					first_q <= 1'b1;
				end else if (col_nxt >= cols) begin
					col_q   <= '0;
					first_q <= 1'b0;
				end else begin
					col_q   <= col_nxt;
					first_q <= first_eff;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_s1          <= cell_value;
			col_s1            <= col;
			ctrl_s1.first     <= first_eff;
			ctrl_s1.has_left  <= (col != '0);
			ctrl_s1.has_right <= (col_nxt < cols);
			ctrl_s1.last      <= last_cell;
			// the stage-1 cell writes its entry at this same edge
			ctrl_s1.fwd_up    <= valid_s1 && (col_s1 == col);
			ctrl_s1.fwd_right <= valid_s1 && (col_s1 == col_nxt);
		end
	end

endmodule

/* rtl/mfps_score.sv */
// Compute stage: three-way max, saturating add, row maximum and the
// result register. Uses mfps_pkg.
module mfps_score import mfps_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int SUM_BITS   = SUM_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_s1,
	input  logic [VALUE_BITS-1:0] value_s1,
	input  s1_ctrl_t              ctrl_s1,
	input  logic [SUM_BITS-1:0]   rdata0,
	input  logic [SUM_BITS-1:0]   rdata1,
	output logic                  ram_we,
	output logic [SUM_BITS-1:0]   ram_wdata,
	output logic                  res_valid,
	input  logic                  res_ready,
	output logic [OUT_W-1:0]      res_data
);

	localparam int VW = ((VALUE_BITS > SUM_BITS) ? VALUE_BITS : SUM_BITS) + 1;
	localparam int AW = SUM_BITS + 1;
	localparam int OW = (SUM_BITS > OUT_W) ? SUM_BITS : OUT_W;

	localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
	localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};
	localparam logic signed [VW-1:0] VMAX = {{(VW-SUM_BITS+1){1'b0}}, {(SUM_BITS-1){1'b1}}};
	localparam logic signed [VW-1:0] VMIN = ~VMAX;
	localparam logic signed [OW-1:0] OMAX = {{(OW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
	localparam logic signed [OW-1:0] OMIN = ~OMAX;

	logic signed [SUM_BITS-1:0] old_left_q;
	logic signed [SUM_BITS-1:0] row_best_q;
	logic signed [SUM_BITS-1:0] last_wr_q;
	logic                       res_valid_q;
	logic [OUT_W-1:0]           res_data_q;

	logic signed [SUM_BITS-1:0] up;
	logic signed [SUM_BITS-1:0] right;
	logic signed [SUM_BITS-1:0] best;
	logic signed [VW-1:0]       val_w;
	logic signed [SUM_BITS-1:0] val_sum;
	logic signed [AW-1:0]       sum_w;
	logic signed [SUM_BITS-1:0] sum_sat;
	logic signed [SUM_BITS-1:0] score;
	logic signed [SUM_BITS-1:0] rb;
	logic signed [SUM_BITS-1:0] rb_new;
	logic signed [OW-1:0]       rb_w;
	logic signed [OW-1:0]       rb_out;

	always_comb begin
		up    = ctrl_s1.fwd_up ? last_wr_q : $signed(rdata0);
		right = ctrl_s1.fwd_right ? last_wr_q : $signed(rdata1);
		best  = up;
		if (ctrl_s1.has_left && (old_left_q > best)) begin
			best = old_left_q;
		end
		if (ctrl_s1.has_right && (right > best)) begin
			best = right;
		end

		val_w = VW'($signed(value_s1));
		if (val_w > VMAX) begin
			val_sum = SUM_MAX;
		end else if (val_w < VMIN) begin
			val_sum = SUM_MIN;
		end else begin
			val_sum = val_w[SUM_BITS-1:0];
		end

		sum_w = AW'(val_sum) + AW'(best);
		if (sum_w[AW-1] != sum_w[AW-2]) begin
			sum_sat = sum_w[AW-1] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_sat = sum_w[SUM_BITS-1:0];
		end
		score = ctrl_s1.first ? val_sum : sum_sat;

		// column 0 opens a fresh row maximum
		rb     = ctrl_s1.has_left ? row_best_q : SUM_MIN;
		rb_new = (score > rb) ? score : rb;

		rb_w = OW'(rb_new);
		if (rb_w > OMAX) begin
			rb_out = OMAX;
		end else if (rb_w < OMIN) begin
			rb_out = OMIN;
		end else begin
			rb_out = rb_w;
		end
	end

	assign ram_we    = valid_s1;
	assign ram_wdata = score;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			old_left_q  <= '0;
			row_best_q  <= SUM_MIN;
			res_valid_q <= 1'b0;
		end else begin
			if (valid_s1) begin
				old_left_q <= up;
				row_best_q <= rb_new;
			end
			if (valid_s1 && ctrl_s1.last) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			last_wr_q <= score;
		end
		if (valid_s1 && ctrl_s1.last) begin
			res_data_q <= rb_out[OUT_W-1:0];
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;

endmodule
